// ===== src/ppe_pkg.sv =====
// ---------------------------------------------------------------------------
// ppe_pkg
// Shared types and constants of the Playfair pair encryptor.
// ---------------------------------------------------------------------------
package ppe_pkg;

  // Square geometry
  localparam int unsigned SquareSideDefault = 5;

  // Letter codes
  localparam int unsigned LetterW = 5;
  localparam int unsigned Letters = 26;
  localparam logic [LetterW-1:0] CodeA = 5'd0;
  localparam logic [LetterW-1:0] CodeI = 5'd8;
  localparam logic [LetterW-1:0] CodeJ = 5'd9;
  localparam logic [LetterW-1:0] CodeX = 5'd23;
  localparam logic [LetterW-1:0] CodeZ = 5'd25;

  // Key storage
  localparam int unsigned KeyMax      = 25;
  localparam int unsigned CfgIndexW   = 3;
  localparam int unsigned CfgDataW    = 35;
  localparam int unsigned KeyLettersW = KeyMax * LetterW;

  // Register indexes of the configuration port
  typedef enum logic [CfgIndexW-1:0] {
    RegKeyLength  = 3'd0,
    RegKeyLettersA = 3'd1,
    RegKeyLettersB = 3'd2,
    RegKeyLettersC = 3'd3,
    RegKeyLettersD = 3'd4
  } cfg_reg_e;

  // Square build sequencer
  typedef enum logic [1:0] {
    BuildKey,
    BuildAlpha,
    BuildDone
  } build_state_e;

  // Channel payloads
  typedef struct packed {
    logic [LetterW-1:0] first_letter;
    logic [LetterW-1:0] second_letter;
    logic               second_present;
  } in_t;

  typedef struct packed {
    logic [LetterW-1:0] cipher_first;
    logic [LetterW-1:0] cipher_second;
  } out_t;

endpackage

// ===== src/ppe_ram.sv =====
// ---------------------------------------------------------------------------
// ppe_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module ppe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports, held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== src/playfair_pair_encryptor_core.sv =====
// ---------------------------------------------------------------------------
// playfair_pair_encryptor_core
// Playfair encryption of one letter pair per transfer on a 5x5 key square.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one letter pair
//   per transfer; output channel (out_valid_o / out_ready_i / out_data_o)
//   returns one ciphertext pair per input transfer, in order.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes the key length
//   and the key letter words; it is always ready. Each write to a known
//   register restarts the square build; unknown indexes are dropped.
//   Building steps through the key letters (at most 25), turns over once, then
//   through the alphabet letters; in_ready_o stays low meanwhile.
//   After reset the build runs once with an empty key.
// Pipeline:
//   The position memory is read at the input transfer edge and the square
//   memory when the pipeline next advances; out_valid_o rises with the square
//   read data. One pair per cycle while out_ready_i does not stall the
//   output, set by the two read ports of each memory.
// Stall:
//   When out_ready_i is low with a result pending, the whole pipeline holds
//   and in_ready_o drops in the same cycle; no result is lost.
// ---------------------------------------------------------------------------
module playfair_pair_encryptor_core import ppe_pkg::*; #(
  parameter int unsigned SquareSide = SquareSideDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // Input pairs
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  // Output pairs
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o
);

  localparam int unsigned Cells = SquareSide * SquareSide;
  localparam int unsigned PosW  = $clog2(Cells);
  localparam int unsigned RcW   = $clog2(SquareSide);

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [LetterW-1:0]     key_length_q;
  logic [KeyLettersW-1:0] key_letters_q;
  logic                   cfg_write;
  logic                   build_start;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  always_comb begin
    build_start = 1'b0;
    if (cfg_write) begin
      case (cfg_index_i)
        RegKeyLength, RegKeyLettersA, RegKeyLettersB,
        RegKeyLettersC, RegKeyLettersD: build_start = 1'b1;
        default: build_start = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q  <= '0;
      key_letters_q <= '0;
    end else if (cfg_write) begin
      case (cfg_index_i)
        RegKeyLength:   key_length_q <= cfg_data_i[LetterW-1:0];
        RegKeyLettersA: key_letters_q[0  +: 35] <= cfg_data_i;
        RegKeyLettersB: key_letters_q[35 +: 35] <= cfg_data_i;
        RegKeyLettersC: key_letters_q[70 +: 35] <= cfg_data_i;
        RegKeyLettersD: key_letters_q[105 +: 20] <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Square build sequencer
  // -------------------------------------------------------------------------
  build_state_e       state_q, state_d;
  logic [LetterW-1:0] idx_q, idx_d;
  logic [PosW-1:0]    fill_q, fill_d;
  logic [Letters-1:0] used_q, used_d;
  logic [LetterW-1:0] key_len_sat;
  logic [LetterW-1:0] key_code;
  logic [LetterW-1:0] wr_letter;
  logic               wr_en;

  assign key_len_sat = (key_length_q > LetterW'(KeyMax)) ? LetterW'(KeyMax) : key_length_q;
  assign key_code    = key_letters_q[idx_q*LetterW +: LetterW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BuildKey;
      idx_q   <= '0;
      fill_q  <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      fill_q  <= fill_d;
      used_q  <= used_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    fill_d    = fill_q;
    used_d    = used_q;
    wr_en     = 1'b0;
    wr_letter = key_code;
    case (state_q)
      // Place key letters, dropping j, bad codes and repeats
      BuildKey: begin
        if (idx_q >= key_len_sat) begin
          state_d = BuildAlpha;
          idx_d   = CodeA;
        end else begin
          idx_d = idx_q + 1'b1;
          if (key_code <= CodeZ && key_code != CodeJ) begin
            if (!used_q[key_code]) begin
              wr_en  = 1'b1;
            end
          end
        end
      end
      // Fill the rest with the alphabet without j
      BuildAlpha: begin
        wr_letter = idx_q;
        if (idx_q != CodeJ && !used_q[idx_q]) begin
          wr_en = 1'b1;
        end
        if (idx_q == CodeZ) begin
          state_d = BuildDone;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      BuildDone: ;
      default: state_d = BuildDone;
    endcase
    if (wr_en) begin
      used_d[wr_letter] = 1'b1;
      fill_d            = fill_q + 1'b1;
    end
    // Restart on any write to a known configuration register
    if (build_start) begin
      state_d = BuildKey;
      idx_d   = '0;
      fill_d  = '0;
      used_d  = '0;
    end
  end

  // -------------------------------------------------------------------------
  // Lookup pipeline control (interlocked against the build)
  // -------------------------------------------------------------------------
  logic pos_valid_q;
  logic out_valid_q;
  logic advance;
  logic in_xfer;

  assign advance    = ~out_valid_q | out_ready_i;
  assign in_ready_o = advance & (state_q == BuildDone);
  assign in_xfer    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      pos_valid_q <= in_xfer;
      out_valid_q <= pos_valid_q;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 0: clean the pair and read both positions
  // -------------------------------------------------------------------------
  logic [LetterW-1:0] let_a;
  logic [LetterW-1:0] let_b_raw;
  logic [LetterW-1:0] let_b;

  function automatic logic [LetterW-1:0] clean_letter(input logic [LetterW-1:0] raw);
    logic [LetterW-1:0] c;
    c = (raw > CodeZ) ? CodeZ : raw;
    if (c == CodeJ) begin
      c = CodeI;
    end
    return c;
  endfunction

  always_comb begin
    let_a     = clean_letter(in_data_i.first_letter);
    let_b_raw = in_data_i.second_present ? clean_letter(in_data_i.second_letter) : CodeX;
    let_b     = (let_a == let_b_raw) ? CodeX : let_b_raw;
  end

  logic [PosW-1:0] pos_a;
  logic [PosW-1:0] pos_b;

  ppe_ram #(
    .Width (PosW),
    .Depth (Letters)
  ) u_pos_ram (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_letter),
    .wdata_i   (fill_q),
    .re_i      (advance),
    .raddr_a_i (let_a),
    .raddr_b_i (let_b),
    .rdata_a_o (pos_a),
    .rdata_b_o (pos_b)
  );

  // -------------------------------------------------------------------------
  // Stage 1: split positions, apply the Playfair rules, read the square
  // -------------------------------------------------------------------------
  function automatic logic [RcW-1:0] pos_row(input logic [PosW-1:0] p);
    logic [RcW-1:0] r;
    r = '0;
    for (int unsigned i = 1; i < SquareSide; i++) begin
      if (p >= PosW'(i * SquareSide)) begin
        r = RcW'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [RcW-1:0] wrap_inc(input logic [RcW-1:0] v);
    return (v == RcW'(SquareSide - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [PosW-1:0] cell_addr(input logic [RcW-1:0] r,
                                                input logic [RcW-1:0] c);
    return PosW'(r) * PosW'(SquareSide) + PosW'(c);
  endfunction

  logic [RcW-1:0]  row_a, col_a, row_b, col_b;
  logic [PosW-1:0] sq_addr_a, sq_addr_b;

  always_comb begin
    row_a = pos_row(pos_a);
    row_b = pos_row(pos_b);
    col_a = RcW'(pos_a - cell_addr(row_a, '0));
    col_b = RcW'(pos_b - cell_addr(row_b, '0));
    if (row_a == row_b) begin
      sq_addr_a = cell_addr(row_a, wrap_inc(col_a));
      sq_addr_b = cell_addr(row_b, wrap_inc(col_b));
    end else if (col_a == col_b) begin
      sq_addr_a = cell_addr(wrap_inc(row_a), col_a);
      sq_addr_b = cell_addr(wrap_inc(row_b), col_b);
    end else begin
      sq_addr_a = cell_addr(row_a, col_b);
      sq_addr_b = cell_addr(row_b, col_a);
    end
  end

  logic [LetterW-1:0] sq_a;
  logic [LetterW-1:0] sq_b;

  ppe_ram #(
    .Width (LetterW),
    .Depth (Cells)
  ) u_square_ram (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (fill_q),
    .wdata_i   (wr_letter),
    .re_i      (advance),
    .raddr_a_i (sq_addr_a),
    .raddr_b_i (sq_addr_b),
    .rdata_a_o (sq_a),
    .rdata_b_o (sq_b)
  );

  // -------------------------------------------------------------------------
  // Stage 2: square read data is the held result
  // -------------------------------------------------------------------------
  assign out_valid_o              = out_valid_q;
  assign out_data_o.cipher_first  = sq_a;
  assign out_data_o.cipher_second = sq_b;

endmodule
